// File: hdl/jst_pkg.sv
// Shared types, constants and codes of the job slot table.
`default_nettype none

package jst_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int REQ_W  = 3;
    localparam int PID_W  = 22;
    localparam int JOB_W  = 5;
    localparam int ST_W   = 2;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam int JOB_LIMIT = 31;
    // The next job number wraps once it passes either the table size or the field range.
    localparam int NEXT_CAP  = (TABLE_ENTRIES < JOB_LIMIT) ? TABLE_ENTRIES : JOB_LIMIT;
    localparam logic [JOB_W:0]   NEXT_CAP_V  = NEXT_CAP[JOB_W:0];
    localparam logic [JOB_W:0]   JOB_LIMIT_V = JOB_LIMIT[JOB_W:0];
    localparam logic [JOB_W-1:0] JOB_FIRST   = JOB_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [ST_W-1:0] RUN_UNDEF = 2'd0;
    localparam logic [ST_W-1:0] RUN_FG    = 2'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 3'd0,
        REQ_DEL     = 3'd1,
        REQ_FIND_P  = 3'd2,
        REQ_FIND_J  = 3'd3,
        REQ_SET_P   = 3'd4,
        REQ_SET_J   = 3'd5,
        REQ_FG      = 3'd6
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_INVALID   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMP_FREE = 3'd0,
        CMP_PID  = 3'd1,
        CMP_JOB  = 3'd2,
        CMP_FG   = 3'd3,
        CMP_MAX  = 3'd4
    } t_cmp_mode;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [JOB_W-1:0] job;
        logic [ST_W-1:0]  state;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_cmp_mode        mode;
        logic [PID_W-1:0] key_pid;
        logic [JOB_W-1:0] key_job;
        logic [JOB_W-1:0] max_job;
    } t_cmp_ctl;

    typedef struct packed {
        logic hit;
    } t_cmp_res;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [PID_W-1:0]  pid;
        logic [JOB_W-1:0]  job;
        logic [ST_W-1:0]   state;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

`default_nettype wire

// File: hdl/jst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module jst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/jst_cmp.sv
// Shared compare unit used by every table scan: key match, foreground test, running maximum.
`default_nettype none

module jst_cmp
    import jst_pkg::*;
(
    input  wire t_cmp_ctl i_ctl,
    input  wire t_entry   i_entry,
    output t_cmp_res      o_res
);

    always_comb begin
        o_res.hit = 1'b0;
        unique case (i_ctl.mode)
            CMP_FREE: o_res.hit = (i_entry.pid == '0);
            CMP_PID:  o_res.hit = (i_entry.pid == i_ctl.key_pid);
            CMP_JOB:  o_res.hit = (i_entry.job == i_ctl.key_job);
            CMP_FG:   o_res.hit = (i_entry.state == RUN_FG);
            CMP_MAX:  o_res.hit = (i_entry.job > i_ctl.max_job);
            default:  o_res.hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/job_slot_table.sv
// Job slot table top level: request sequencer, slot memory and result register.
//
//  Channel   Dir  Handshake                          Payload
//  request   in   i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata (32 bits)
//  result    out  o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata (40 bits)
//
// A request walks the slots one at a time through the compare unit, with a read state
// and a check state per slot because the slot memory has a registered read port. A
// delete follows its lookup with a full maximum scan over every slot. A request with an
// invalid key or an unused code skips the scan and goes straight to the result state.
// Reset clears the per-slot valid bits at once, so no clearing pass is needed.
// The block takes a new request while the previous result waits in the output
// register, but holds its next result until that register is free.
`default_nettype none

module job_slot_table
    import jst_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [2:0] req_type, [24:3] proc_id, [29:25] job_num, [31:30] new_state
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [1:0] status, [5:2] found_slot, [27:6] out_proc_id, [32:28] out_job_num,
    // [34:33] out_state, [39:35] zero
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_MAXRD = 7'b0010000,
        S_MAXCK = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    t_req                     r_req;
    logic [PID_W-1:0]         r_pid;
    logic [JOB_W-1:0]         r_job;
    logic [ST_W-1:0]          r_st;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_hit_idx;
    t_entry                   r_hit_entry;
    logic [JOB_W-1:0]         r_max, n_max;
    logic [JOB_W-1:0]         r_next_job, n_next_job;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_rd_vld;
    t_result                  r_res, n_res;
    t_result                  r_out;
    logic                     r_out_vld;

    logic                     s_accept;
    logic                     out_load;
    logic                     ram_we;
    t_entry                   ram_wdata;
    logic                     ram_re;
    logic [ENTRY_W-1:0]       ram_rdata;
    t_entry                   cur_entry;
    t_cmp_ctl                 cmp_ctl;
    t_cmp_res                 cmp_res;
    t_req                     in_req;
    logic [PID_W-1:0]         in_pid;
    logic [JOB_W-1:0]         in_job;
    logic [JOB_W:0]           job_inc;
    logic [JOB_W:0]           max_inc;
    logic [JOB_W-1:0]         max_new;
    logic                     last;

    assign in_req = t_req'(i_s_axis_tdata[2:0]);
    assign in_pid = i_s_axis_tdata[24:3];
    assign in_job = i_s_axis_tdata[29:25];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_RESP) && (!r_out_vld || i_m_axis_tready);
    assign last            = (r_idx == IDX_LAST);

    jst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_hit_idx),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rdata)
    );

    // A slot that was never written or was freed reads as all zeros.
    assign cur_entry = r_rd_vld ? t_entry'(ram_rdata) : '0;
    assign ram_re    = (r_state == S_READ) || (r_state == S_MAXRD);

    always_comb begin
        cmp_ctl.key_pid = r_pid;
        cmp_ctl.key_job = r_job;
        cmp_ctl.max_job = r_max;
        if (r_state == S_MAXCK) begin
            cmp_ctl.mode = CMP_MAX;
        end else begin
            case (r_req) inside
                REQ_ADD:                             cmp_ctl.mode = CMP_FREE;
                REQ_DEL, REQ_FIND_P, REQ_SET_P:      cmp_ctl.mode = CMP_PID;
                REQ_FIND_J, REQ_SET_J:               cmp_ctl.mode = CMP_JOB;
                default:                             cmp_ctl.mode = CMP_FG;
            endcase
        end
    end

    jst_cmp u_cmp (
        .i_ctl   (cmp_ctl),
        .i_entry (cur_entry),
        .o_res   (cmp_res)
    );

    assign job_inc = {1'b0, r_next_job} + (JOB_W+1)'(1);
    assign max_new = cmp_res.hit ? cur_entry.job : r_max;
    assign max_inc = {1'b0, max_new} + (JOB_W+1)'(1);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_max      = r_max;
        n_next_job = r_next_job;
        n_valid    = r_valid;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_wdata  = r_hit_entry;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_idx = '0;
                    n_res = '{status: STAT_NOT_FOUND, default: '0};
                    case (in_req) inside
                        REQ_ADD, REQ_DEL, REQ_FIND_P, REQ_SET_P: begin
                            if (in_pid == '0) begin
                                n_res.status = STAT_INVALID;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        REQ_FIND_J, REQ_SET_J: begin
                            if (in_job == '0) begin
                                n_res.status = STAT_INVALID;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        REQ_FG: n_state = S_READ;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (cmp_res.hit) begin
                    n_state = S_APPLY;
                end else if (last) begin
                    n_res   = '{status: STAT_NOT_FOUND, default: '0};
                    if (r_req == REQ_ADD) begin
                        n_res.status = STAT_FULL;
                    end
                    n_state = S_RESP;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_READ;
                end
            end
            S_APPLY: begin
                n_res.status = STAT_OK;
                n_res.slot   = SLOT_W'(r_hit_idx);
                n_res.pid    = r_hit_entry.pid;
                n_res.job    = r_hit_entry.job;
                n_res.state  = r_hit_entry.state;
                n_state      = S_RESP;
                case (r_req) inside
                    REQ_ADD: begin
                        ram_we             = 1'b1;
                        ram_wdata.pid      = r_pid;
                        ram_wdata.job      = r_next_job;
                        ram_wdata.state    = r_st;
                        n_valid[r_hit_idx] = 1'b1;
                        n_res.pid          = r_pid;
                        n_res.job          = r_next_job;
                        n_res.state        = r_st;
                        n_next_job = (job_inc > NEXT_CAP_V) ? JOB_FIRST : job_inc[JOB_W-1:0];
                    end
                    REQ_DEL: begin
                        n_valid[r_hit_idx] = 1'b0;
                        n_res.state        = RUN_UNDEF;
                        n_max              = '0;
                        n_idx              = '0;
                        n_state            = S_MAXRD;
                    end
                    REQ_SET_P, REQ_SET_J: begin
                        ram_we          = 1'b1;
                        ram_wdata.state = r_st;
                        n_res.state     = r_st;
                    end
                    default: ;
                endcase
            end
            S_MAXRD: begin
                n_state = S_MAXCK;
            end
            S_MAXCK: begin
                n_max = max_new;
                if (last) begin
                    n_next_job = (max_inc > JOB_LIMIT_V) ? JOB_FIRST : max_inc[JOB_W-1:0];
                    n_state    = S_RESP;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_MAXRD;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_next_job <= JOB_FIRST;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_next_job <= n_next_job;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_max <= n_max;
        r_res <= n_res;
        if (s_accept) begin
            r_req <= in_req;
            r_pid <= in_pid;
            r_job <= in_job;
            r_st  <= i_s_axis_tdata[31:30];
        end
        if (ram_re) begin
            r_rd_vld <= r_valid[r_idx];
        end
        if (r_state == S_CHECK && cmp_res.hit) begin
            r_hit_idx   <= r_idx;
            r_hit_entry <= cur_entry;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), r_out.state, r_out.job,
                              r_out.pid, r_out.slot, r_out.status};

    // A new request is never taken while another one is still being worked.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // The scan index stays inside the table whenever the memory is read.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_idx <= IDX_LAST))
        else $error("scan index beyond table");

    // A delete frees its slot before the maximum scan reads it.
    a_del_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_req == REQ_DEL) |=> !r_valid[$past(r_hit_idx)])
        else $error("deleted slot still valid");

    // A result taken from the sequencer shows up on the output the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_axis_tvalid && r_state == S_IDLE))
        else $error("result not presented");

    // The next job number never leaves the range one to the wrap limit.
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_job != '0) && ({1'b0, r_next_job} <= NEXT_CAP_V
                               || {1'b0, r_next_job} <= JOB_LIMIT_V))
        else $error("next job number out of range");

endmodule

`default_nettype wire

// File: bench/job_slot_table_test.sv
// Self-checking bench for the job slot table: directed and random requests, checked against a shadow table.
module job_slot_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jst_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED   = 3'd7;
    localparam int               RANDOM_ITEMS = 257;
    localparam int               STALL_LIMIT  = 4000;
    // Longest request is a delete: a lookup scan plus a full maximum scan.
    localparam int               DRAIN_CYCLES = 4 * TABLE_ENTRIES + 16;

    // Shadow copy of the slot table that works out the reply of every accepted request.
    class slot_table_shadow;
        logic [PID_W-1:0] slot_pid   [TABLE_ENTRIES];
        logic [JOB_W-1:0] slot_job   [TABLE_ENTRIES];
        logic [ST_W-1:0]  slot_state [TABLE_ENTRIES];
        int               next_job;
        t_result          awaited_replies [$];
        int               mismatches;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_pid[i]   = '0;
                slot_job[i]   = '0;
                slot_state[i] = RUN_UNDEF;
            end
            next_job   = 1;
            mismatches = 0;
        endfunction

        function int slot_of_pid(logic [PID_W-1:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_pid[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [PID_W-1:0] pid,
                                   logic [JOB_W-1:0] job, logic [ST_W-1:0] st);
            t_result reply;
            int      s;
            int      top;
            reply        = '0;
            reply.status = STAT_NOT_FOUND;
            s            = -1;
            case (req) inside
                REQ_ADD: begin
                    if (pid == '0) begin
                        reply.status = STAT_INVALID;
                    end else begin
                        s = slot_of_pid('0);
                        if (s < 0) begin
                            reply.status = STAT_FULL;
                        end else begin
                            slot_pid[s]   = pid;
                            slot_state[s] = st;
                            slot_job[s]   = JOB_W'(next_job);
                            next_job      = next_job + 1;
                            if (next_job > TABLE_ENTRIES || next_job > JOB_LIMIT) begin
                                next_job = 1;
                            end
                            reply.status = STAT_OK;
                        end
                    end
                end
                REQ_DEL: begin
                    if (pid == '0) begin
                        reply.status = STAT_INVALID;
                    end else begin
                        s = slot_of_pid(pid);
                        if (s >= 0) begin
                            // The reply names the freed slot with its old keys and a cleared state.
                            reply.status  = STAT_OK;
                            reply.slot    = SLOT_W'(s);
                            reply.pid     = slot_pid[s];
                            reply.job     = slot_job[s];
                            reply.state   = RUN_UNDEF;
                            slot_pid[s]   = '0;
                            slot_job[s]   = '0;
                            slot_state[s] = RUN_UNDEF;
                            top = 0;
                            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                if (slot_job[i] > top) begin
                                    top = slot_job[i];
                                end
                            end
                            next_job = top + 1;
                            if (next_job > JOB_LIMIT) begin
                                next_job = 1;
                            end
                            s = -1;
                        end
                    end
                end
                REQ_FIND_P, REQ_SET_P: begin
                    if (pid == '0) begin
                        reply.status = STAT_INVALID;
                    end else begin
                        s = slot_of_pid(pid);
                        if (s >= 0) begin
                            reply.status = STAT_OK;
                            if (req == REQ_SET_P) begin
                                slot_state[s] = st;
                            end
                        end
                    end
                end
                REQ_FIND_J, REQ_SET_J: begin
                    if (job == '0) begin
                        reply.status = STAT_INVALID;
                    end else begin
                        for (int i = 0; i < TABLE_ENTRIES && s < 0; i++) begin
                            if (slot_job[i] == job) begin
                                s = i;
                            end
                        end
                        if (s >= 0) begin
                            reply.status = STAT_OK;
                            if (req == REQ_SET_J) begin
                                slot_state[s] = st;
                            end
                        end
                    end
                end
                REQ_FG: begin
                    for (int i = 0; i < TABLE_ENTRIES && s < 0; i++) begin
                        if (slot_state[i] == RUN_FG) begin
                            s = i;
                        end
                    end
                    if (s >= 0) begin
                        reply.status = STAT_OK;
                    end
                end
                default: begin
                    reply.status = STAT_NOT_FOUND;
                end
            endcase
            if (s >= 0) begin
                reply.slot  = SLOT_W'(s);
                reply.pid   = slot_pid[s];
                reply.job   = slot_job[s];
                reply.state = slot_state[s];
            end
            awaited_replies.push_back(reply);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            t_result seen;
            t_result want;
            seen.status = t_status'(beat[1:0]);
            seen.slot   = beat[5:2];
            seen.pid    = beat[27:6];
            seen.job    = beat[32:28];
            seen.state  = beat[34:33];
            if (awaited_replies.size() == 0) begin
                $error("reply with no request outstanding: tdata %h", beat);
                mismatches++;
                return;
            end
            want = awaited_replies.pop_front();
            if (seen.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, seen.status);
                mismatches++;
            end
            if (seen.slot != want.slot) begin
                $error("found_slot: expected %0d, got %0d", want.slot, seen.slot);
                mismatches++;
            end
            if (seen.pid != want.pid) begin
                $error("out_proc_id: expected %0d, got %0d", want.pid, seen.pid);
                mismatches++;
            end
            if (seen.job != want.job) begin
                $error("out_job_num: expected %0d, got %0d", want.job, seen.job);
                mismatches++;
            end
            if (seen.state != want.state) begin
                $error("out_state: expected %0d, got %0d", want.state, seen.state);
                mismatches++;
            end
            if (beat[39:35] != '0) begin
                $error("tdata padding: expected 0, got %0d", beat[39:35]);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] rsp_data;

    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     quiet_cycles   = 0;
    logic [PID_W-1:0]       pid_pool [16];
    slot_table_shadow       shadow;

    job_slot_table u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic push_request(input logic [REQ_W-1:0] req, input logic [PID_W-1:0] pid,
                                input logic [JOB_W-1:0] job, input logic [ST_W-1:0] st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {st, job, pid, req};
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        shadow.note_request(req, pid, job, st);
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            shadow.check_result(rsp_data);
        end
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int               mode;
        int               roll;
        int               pick;
        int               add_pct;
        int               del_pct;
        logic [REQ_W-1:0] req;
        logic [PID_W-1:0] pid;
        logic [JOB_W-1:0] job;
        logic [ST_W-1:0]  st;

        shadow      = new();
        mode        = 0;
        pid_pool[0] = '1;
        pid_pool[1] = PID_W'(1);
        pid_pool[2] = 22'h2AAAAA;
        pid_pool[3] = 22'h155555;
        for (int i = 4; i < 16; i++) begin
            pid_pool[i] = PID_W'($urandom_range(2, 4194303));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, unused code and a zero key on every keyed request.
        push_request(REQ_FG, '0, '0, RUN_UNDEF);
        push_request(REQ_UNUSED, '1, JOB_W'(17), 2'd3);
        push_request(REQ_ADD, '0, '0, RUN_FG);
        push_request(REQ_DEL, '0, JOB_W'(1), 2'd2);
        push_request(REQ_FIND_P, '0, JOB_W'(1), 2'd1);
        push_request(REQ_SET_P, '0, JOB_W'(2), 2'd2);
        push_request(REQ_FIND_J, PID_W'(1), '0, 2'd0);
        push_request(REQ_SET_J, PID_W'(1), '0, 2'd3);
        // Fill a few slots, one process id twice, then look them up and move states.
        push_request(REQ_ADD, '1, JOB_W'(17), RUN_FG);
        push_request(REQ_ADD, PID_W'(1), '0, 2'd3);
        push_request(REQ_ADD, PID_W'(1), JOB_W'(5), 2'd2);
        push_request(REQ_FIND_P, PID_W'(1), '0, 2'd0);
        push_request(REQ_FIND_J, '0, JOB_W'(3), 2'd0);
        push_request(REQ_FIND_J, '0, JOB_W'(17), 2'd0);
        push_request(REQ_FIND_P, 22'h2AAAAA, '0, 2'd0);
        push_request(REQ_FG, '0, '0, 2'd0);
        push_request(REQ_SET_P, '1, '0, RUN_UNDEF);
        push_request(REQ_FG, '0, '0, 2'd0);
        push_request(REQ_SET_J, '0, JOB_W'(2), RUN_FG);
        push_request(REQ_FG, '0, '0, 2'd0);
        push_request(REQ_DEL, PID_W'(1), '0, 2'd0);
        push_request(REQ_DEL, PID_W'(1), '0, 2'd0);
        push_request(REQ_DEL, PID_W'(1), '0, 2'd0);
        push_request(REQ_ADD, 22'h155555, '0, 2'd2);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Runs of mostly adds fill the table and wrap the job number;
                // runs of mostly deletes drain it again.
                if (n % 40 == 0) begin
                    mode = $urandom_range(0, 2);
                end
                case (mode)
                    0: begin
                        add_pct = 55;
                        del_pct = 10;
                    end
                    1: begin
                        add_pct = 25;
                        del_pct = 25;
                    end
                    default: begin
                        add_pct = 8;
                        del_pct = 50;
                    end
                endcase
                roll = $urandom_range(0, 99);
                if (roll < add_pct) begin
                    req = REQ_ADD;
                end else if (roll < add_pct + del_pct) begin
                    req = REQ_DEL;
                end else begin
                    case ($urandom_range(0, 10)) inside
                        0, 1:    req = REQ_FIND_P;
                        2, 3:    req = REQ_FIND_J;
                        4, 5:    req = REQ_SET_P;
                        6, 7:    req = REQ_SET_J;
                        8, 9:    req = REQ_FG;
                        default: req = REQ_UNUSED;
                    endcase
                end
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    pid = '0;
                end else if (pick < 10) begin
                    pid = PID_W'($urandom);
                end else begin
                    pid = pid_pool[$urandom_range(0, 15)];
                end
                job = JOB_W'($urandom_range(0, 17));
                st  = ST_W'($urandom_range(0, 3));
                push_request(req, pid, job, st);
            end
        end
        req_valid <= 1'b0;

        while (shadow.outstanding() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
